// File: rtl/asfmt_pkg.sv
// ---------------------------------------------------------------------------
// asfmt_pkg
// Shared types, constants and segment tables of the autorange formatter.
// ---------------------------------------------------------------------------
`default_nettype none

package asfmt_pkg;

    // Field widths
    localparam int IN_W   = 28;   // value_milli
    localparam int MAG_W  = 24;   // |value| in range, up to 9999000
    localparam int Q_W    = 14;   // scaled number, up to 9999
    localparam int HI_W   = 7;    // two-digit half, up to 99
    localparam int POS_W  = 3;    // point_position
    localparam int SEG_W  = 8;

    // Displayable range, in thousandths
    localparam logic signed [IN_W-1:0] OVF_HI = 28'sd9999000;
    localparam logic signed [IN_W-1:0] OVF_LO = -28'sd999000;

    // Range edges
    localparam logic signed [IN_W-1:0] LIM_1E4 = 28'sd10000;
    localparam logic signed [IN_W-1:0] LIM_1E5 = 28'sd100000;
    localparam logic signed [IN_W-1:0] LIM_1E6 = 28'sd1000000;
    localparam logic signed [IN_W-1:0] NLIM_1E4 = -28'sd10000;
    localparam logic signed [IN_W-1:0] NLIM_1E5 = -28'sd100000;

    // Point positions
    localparam logic [POS_W-1:0] POS_NONE = 3'd0;
    localparam logic [POS_W-1:0] POS_D0   = 3'd1;
    localparam logic [POS_W-1:0] POS_D1   = 3'd2;
    localparam logic [POS_W-1:0] POS_D2   = 3'd3;
    localparam logic [POS_W-1:0] POS_D3   = 3'd4;

    // Active-low segment codes, bit 7 is the point
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'hBF;
    localparam logic [SEG_W-1:0] SEG_LET_O = 8'hC0;
    localparam logic [SEG_W-1:0] SEG_LET_V = 8'hE3;
    localparam logic [SEG_W-1:0] SEG_LET_F = 8'h8E;
    localparam logic [SEG_W-1:0] SEG_LET_L = 8'hC7;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        bcd_t tens;
        bcd_t ones;
    } digit_pair_t;

    function automatic logic [SEG_W-1:0] digit_seg(input bcd_t d);
        logic [SEG_W-1:0] code;
        unique case (d)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/autorange_seven_segment_formatter.sv
// ---------------------------------------------------------------------------
// autorange_seven_segment_formatter
// Signed thousandths to four active-low seven-segment bytes, autoranged.
// ---------------------------------------------------------------------------
// An accepted input beat moves through stages 1 to 6; stage 6 holds the output beat.
// Throughput: one beat per cycle while the output is not stalled; six register
// stages, each with a valid bit, and a stage takes a new beat when it is empty
// or its beat moves on. The widest step is the 24x25 reciprocal multiply
// in stage 2. Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module autorange_seven_segment_formatter (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [27:0] value_milli, [31:28] zero

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [39:0] m_axis_tdata,   // [7:0] seg_digit0, [15:8] seg_digit1,
                                             // [23:16] seg_digit2, [31:24] seg_digit3,
                                             // [34:32] point_position, [39:35] zero
    output      logic [0:0]  m_axis_tuser    // [0] overflow
);

    // Divisor chosen by range
    typedef enum logic [1:0] {
        DIV_1,
        DIV_10,
        DIV_100,
        DIV_1000
    } div_sel_t;

    // -----------------------------------------------------------------------
    // Handshake chain: a stage loads when it is empty or its beat leaves.
    // -----------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !v6_reg || m_axis_tready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: range check, magnitude, point and divisor selection.
    // Compares run on the signed input in parallel with the negation.
    // -----------------------------------------------------------------------
    logic signed [asfmt_pkg::IN_W-1:0]  v_in;
    logic [asfmt_pkg::IN_W-1:0]         abs_in;
    logic                               neg_next;
    logic                               ovf_next;
    logic [asfmt_pkg::POS_W-1:0]        pos_next;
    div_sel_t                           sel_next;

    assign v_in     = signed'(s_axis_tdata[asfmt_pkg::IN_W-1:0]);
    assign neg_next = v_in[asfmt_pkg::IN_W-1];
    assign abs_in   = neg_next ? (~v_in + 28'd1) : v_in;
    assign ovf_next = (v_in > asfmt_pkg::OVF_HI) || (v_in < asfmt_pkg::OVF_LO);

    always_comb
    begin
        if (!neg_next)
        begin
            priority if (v_in < asfmt_pkg::LIM_1E4)
            begin
                pos_next = asfmt_pkg::POS_D0;
                sel_next = DIV_1;
            end
            else if (v_in < asfmt_pkg::LIM_1E5)
            begin
                pos_next = asfmt_pkg::POS_D1;
                sel_next = DIV_10;
            end
            else if (v_in < asfmt_pkg::LIM_1E6)
            begin
                pos_next = asfmt_pkg::POS_D2;
                sel_next = DIV_100;
            end
            else
            begin
                pos_next = asfmt_pkg::POS_NONE;
                sel_next = DIV_1000;
            end
        end
        else
        begin
            priority if (v_in > asfmt_pkg::NLIM_1E4)
            begin
                pos_next = asfmt_pkg::POS_D1;
                sel_next = DIV_10;
            end
            else if (v_in > asfmt_pkg::NLIM_1E5)
            begin
                pos_next = asfmt_pkg::POS_D2;
                sel_next = DIV_100;
            end
            else
            begin
                pos_next = asfmt_pkg::POS_D3;
                sel_next = DIV_1000;
            end
        end
    end

    logic [asfmt_pkg::MAG_W-1:0]  mag1_reg;
    logic                         neg1_reg;
    logic                         ovf1_reg;
    logic [asfmt_pkg::POS_W-1:0]  pos1_reg;
    div_sel_t                     sel1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            mag1_reg <= abs_in[asfmt_pkg::MAG_W-1:0];
            neg1_reg <= neg_next;
            ovf1_reg <= ovf_next;
            pos1_reg <= pos_next;
            sel1_reg <= sel_next;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: multiply by the reciprocal, ceil(2^s / d) with s = 24 + ceil(log2 d).
    // -----------------------------------------------------------------------
    logic [24:0] recip;
    logic [48:0] prod_next;

    always_comb
    begin
        unique case (sel1_reg)
            DIV_1:    recip = 25'd1;
            DIV_10:   recip = 25'd26843546;   // s = 28
            DIV_100:  recip = 25'd21474837;   // s = 31
            DIV_1000: recip = 25'd17179870;   // s = 34
            default:  recip = 25'd1;
        endcase
    end

    assign prod_next = 49'(mag1_reg) * 49'(recip);

    logic [48:0]                  prod2_reg;
    logic                         neg2_reg;
    logic                         ovf2_reg;
    logic [asfmt_pkg::POS_W-1:0]  pos2_reg;
    div_sel_t                     sel2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            prod2_reg <= prod_next;
            neg2_reg  <= neg1_reg;
            ovf2_reg  <= ovf1_reg;
            pos2_reg  <= pos1_reg;
            sel2_reg  <= sel1_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 3: take the quotient; the minus only shows for a nonzero number.
    // -----------------------------------------------------------------------
    logic [asfmt_pkg::Q_W-1:0] q_next;

    always_comb
    begin
        unique case (sel2_reg)
            DIV_1:    q_next = prod2_reg[13:0];
            DIV_10:   q_next = prod2_reg[41:28];
            DIV_100:  q_next = prod2_reg[44:31];
            DIV_1000: q_next = prod2_reg[47:34];
            default:  q_next = prod2_reg[13:0];
        endcase
    end

    logic [asfmt_pkg::Q_W-1:0]    q3_reg;
    logic                         neg3_reg;
    logic                         ovf3_reg;
    logic [asfmt_pkg::POS_W-1:0]  pos3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            q3_reg   <= q_next;
            neg3_reg <= neg2_reg && (q_next != '0);
            ovf3_reg <= ovf2_reg;
            pos3_reg <= pos2_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 4: upper half, q / 100 = (q * 20972) >> 21 for q < 2^14.
    // -----------------------------------------------------------------------
    logic [28:0] hi_prod;

    assign hi_prod = 29'(q3_reg) * 29'(20972);

    logic [asfmt_pkg::Q_W-1:0]    q4_reg;
    logic [asfmt_pkg::HI_W-1:0]   hi4_reg;
    logic                         neg4_reg;
    logic                         ovf4_reg;
    logic [asfmt_pkg::POS_W-1:0]  pos4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            q4_reg   <= q3_reg;
            hi4_reg  <= hi_prod[27:21];
            neg4_reg <= neg3_reg;
            ovf4_reg <= ovf3_reg;
            pos4_reg <= pos3_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 5: lower half, q - 100 * hi, by shifts and adds.
    // -----------------------------------------------------------------------
    logic [asfmt_pkg::Q_W-1:0] hi_x100;
    logic [asfmt_pkg::Q_W-1:0] lo_full;

    assign hi_x100 = (14'(hi4_reg) << 6) + (14'(hi4_reg) << 5) + (14'(hi4_reg) << 2);
    assign lo_full = q4_reg - hi_x100;

    logic [asfmt_pkg::HI_W-1:0]   hi5_reg;
    logic [asfmt_pkg::HI_W-1:0]   lo5_reg;
    logic                         neg5_reg;
    logic                         ovf5_reg;
    logic [asfmt_pkg::POS_W-1:0]  pos5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            hi5_reg  <= hi4_reg;
            lo5_reg  <= lo_full[asfmt_pkg::HI_W-1:0];
            neg5_reg <= neg4_reg;
            ovf5_reg <= ovf4_reg;
            pos5_reg <= pos4_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 6: digits, segment codes, point and overflow text; output register.
    // A negative number is below 1000, so its hundreds digit is hi's ones.
    // -----------------------------------------------------------------------
    asfmt_pkg::digit_pair_t hi_digits;
    asfmt_pkg::digit_pair_t lo_digits;

    asfmt_digit_split u_split_hi (
        .value  (hi5_reg),
        .digits (hi_digits)
    );

    asfmt_digit_split u_split_lo (
        .value  (lo5_reg),
        .digits (lo_digits)
    );

    logic [asfmt_pkg::SEG_W-1:0] seg0_next, seg1_next, seg2_next, seg3_next;
    logic [asfmt_pkg::POS_W-1:0] pos_out_next;

    always_comb
    begin
        if (ovf5_reg)
        begin
            seg0_next    = asfmt_pkg::SEG_LET_O;
            seg1_next    = asfmt_pkg::SEG_LET_V;
            seg2_next    = asfmt_pkg::SEG_LET_F;
            seg3_next    = asfmt_pkg::SEG_LET_L;
            pos_out_next = asfmt_pkg::POS_NONE;
        end
        else
        begin
            seg0_next    = neg5_reg ? asfmt_pkg::SEG_MINUS
                                    : asfmt_pkg::digit_seg(hi_digits.tens);
            seg1_next    = asfmt_pkg::digit_seg(hi_digits.ones);
            seg2_next    = asfmt_pkg::digit_seg(lo_digits.tens);
            seg3_next    = asfmt_pkg::digit_seg(lo_digits.ones);
            pos_out_next = pos5_reg;
            if (pos5_reg == asfmt_pkg::POS_D0) seg0_next[7] = 1'b0;
            if (pos5_reg == asfmt_pkg::POS_D1) seg1_next[7] = 1'b0;
            if (pos5_reg == asfmt_pkg::POS_D2) seg2_next[7] = 1'b0;
            if (pos5_reg == asfmt_pkg::POS_D3) seg3_next[7] = 1'b0;
        end
    end

    logic [asfmt_pkg::SEG_W-1:0] seg0_reg, seg1_reg, seg2_reg, seg3_reg;
    logic [asfmt_pkg::POS_W-1:0] pos6_reg;
    logic                        ovf6_reg;

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            seg0_reg <= seg0_next;
            seg1_reg <= seg1_next;
            seg2_reg <= seg2_next;
            seg3_reg <= seg3_next;
            pos6_reg <= pos_out_next;
            ovf6_reg <= ovf5_reg;
        end
    end

    assign m_axis_tvalid = v6_reg;
    assign m_axis_tdata  = {5'b00000, pos6_reg, seg3_reg, seg2_reg, seg1_reg, seg0_reg};
    assign m_axis_tuser  = ovf6_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_ovf_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && ovf6_reg |-> pos6_reg == asfmt_pkg::POS_NONE)
        else $error("overflow beat carries a point position");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> pos6_reg <= asfmt_pkg::POS_D3)
        else $error("point position out of range");

    a_minus_point: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && !ovf6_reg && seg0_reg[6:0] == asfmt_pkg::SEG_MINUS[6:0]
        |-> pos6_reg >= asfmt_pkg::POS_D1)
        else $error("minus shown without a negative range point");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted beat lost at stage 1");

endmodule

`default_nettype wire

// File: rtl/asfmt_digit_split.sv
// ---------------------------------------------------------------------------
// asfmt_digit_split
// Splits a value below 100 into tens and ones by reciprocal multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module asfmt_digit_split (
    input  wire logic [asfmt_pkg::HI_W-1:0] value,
    output asfmt_pkg::digit_pair_t          digits
);

    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;

    // x*205 >> 11 == x/10 for x < 1029
    assign prod     = 15'(value) * 15'(205);
    assign tens     = prod[14:11];
    assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    assign ones     = value - tens_x10;

    assign digits.tens = tens;
    assign digits.ones = ones[3:0];

endmodule

`default_nettype wire
